// ===== src/pcfc_pkg.sv =====
// Package for the pixel channel format converter: shared types, register
// indexes, channel numbering and the small scaling helper functions.
// No dependencies.
package pcfc_pkg;

  localparam int NUM_CH = 3;

  // Channel numbering matches the byte position in a 0xRRGGBB color.
  localparam int CH_BLUE  = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_RED   = 2;

  // Configuration register indexes.
  localparam logic [2:0] REG_RED_OFFSET     = 3'd0;
  localparam logic [2:0] REG_RED_WIDTH      = 3'd1;
  localparam logic [2:0] REG_GREEN_OFFSET   = 3'd2;
  localparam logic [2:0] REG_GREEN_WIDTH    = 3'd3;
  localparam logic [2:0] REG_BLUE_OFFSET    = 3'd4;
  localparam logic [2:0] REG_BLUE_WIDTH     = 3'd5;
  localparam logic [2:0] REG_PIXEL_IS_32BIT = 3'd6;

  localparam logic CMD_PACK   = 1'b0;
  localparam logic CMD_UNPACK = 1'b1;

  localparam int X_W     = 15;  // dividend width, max 32512
  localparam int DW_W    = 4;   // divisor code: divisor = 2^code - 1
  localparam int RECIP_W = 17;  // floor(2^16 / divisor)
  localparam int QE_W    = 16;

  typedef struct packed {
    logic [NUM_CH-1:0][4:0] off;
    logic [NUM_CH-1:0][4:0] wid;
    logic                   is32;
  } pcfc_cfg_t;

  typedef struct packed {
    logic [NUM_CH-1:0][4:0] off;
    logic [NUM_CH-1:0][3:0] wid;
    logic                   fallback;
    logic                   is32;
  } pcfc_layout_t;

  // Per-channel operands for the divide lane.
  typedef struct packed {
    logic [X_W-1:0]  x;
    logic [DW_W-1:0] dw;
  } pcfc_lane_t;

  // Control that rides along with the divide lanes to the output stage.
  typedef struct packed {
    logic                   cmd;
    logic [NUM_CH-1:0][4:0] off;
    logic                   fallback;
    logic                   is32;
  } pcfc_place_t;

  // All-ones mask of w bits, w in 1..8.
  function automatic logic [7:0] field_ones(logic [3:0] w);
    logic [8:0] t;
    t = (9'd1 << w) - 9'd1;
    return t[7:0];
  endfunction

  // floor(65536 / (2^dw - 1)).
  function automatic logic [RECIP_W-1:0] recip(logic [DW_W-1:0] dw);
    logic [RECIP_W-1:0] r;
    case (dw)
      4'd2:    r = 17'd21845;
      4'd3:    r = 17'd9362;
      4'd4:    r = 17'd4369;
      4'd5:    r = 17'd2114;
      4'd6:    r = 17'd1040;
      4'd7:    r = 17'd516;
      4'd8:    r = 17'd257;
      default: r = 17'd65536;
    endcase
    return r;
  endfunction

  // Build the dividend and divisor code for one channel.
  // pack:   (v * ones + 127) / 255, bypass at width 8
  // unpack: (raw * 255 + ones/2) / ones, bypass at width 8
  function automatic pcfc_lane_t lane_prep(logic cmd, logic [7:0] chan_byte,
                                           logic [7:0] field_raw, logic [3:0] w);
    pcfc_lane_t l;
    logic [7:0]  ones;
    logic [15:0] t;
    ones = field_ones(w);
    if (w == 4'd8) begin
      l.x  = X_W'((cmd == CMD_PACK) ? chan_byte : field_raw);
      l.dw = 4'd1;
    end else if (cmd == CMD_PACK) begin
      t    = (16'(chan_byte) << w) - 16'(chan_byte) + 16'd127;
      l.x  = t[X_W-1:0];
      l.dw = 4'd8;
    end else begin
      t    = (16'(field_raw) << 8) - 16'(field_raw) + 16'(ones >> 1);
      l.x  = t[X_W-1:0];
      l.dw = w;
    end
    return l;
  endfunction

endpackage

// ===== src/pcfc_ifs.sv =====
// Valid/ready stream interfaces for the pixel channel format converter.
// No dependencies.
interface pcfc_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] pixel_value;

  modport source (output valid, output command, output pixel_value, input ready);
  modport sink   (input valid, input command, input pixel_value, output ready);
endinterface

interface pcfc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] converted;
  logic        layout_fallback;

  modport source (output valid, output converted, output layout_fallback, input ready);
  modport sink   (input valid, input converted, input layout_fallback, output ready);
endinterface

// ===== src/pixel_channel_format_convert.sv =====
// Top level of the pixel channel format converter.
// Depends on pcfc_pkg, pcfc_ifs, pcfc_layout and pcfc_scale.
//
// Converts one pixel per clock between a logical 0xRRGGBB color and a
// framebuffer word with configurable red/green/blue field offsets and
// widths (command 0 packs, command 1 unpacks), with rounding in both
// directions. Throughput is one transfer per cycle while out ready is
// high; a low out ready stalls the pipe in place. The six register
// stages are input capture, layout check, field extract and dividend
// setup, reciprocal multiply, quotient correction, and field placement
// into the output register. The input transfer edge loads the first
// stage, and out valid rises once the pixel has reached the output
// register. An invalid layout (zero or oversized width, field past the
// pixel width, overlapping fields) falls back to 8:8:8 at 16/8/0 and sets
// layout_fallback. In 24-bit mode the top byte is ignored on unpack and
// zero on pack. Registers are written through cfg_we/cfg_index/cfg_wdata
// and must only change while no pixel is in flight.
module pixel_channel_format_convert (
  input  logic             clk,
  input  logic             rst_n,
  pcfc_in_if.sink          in_ch,
  pcfc_out_if.source       out_ch,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [4:0]       cfg_wdata
);
  import pcfc_pkg::*;

  localparam int NSTG = 6;

  // config registers
  pcfc_cfg_t cfg_r;

  // stage valids and the ready chain; rdy[k] loads stage k
  logic [NSTG:1]   vld_r;
  logic [NSTG+1:1] rdy;

  // stage 1: captured input
  logic        s1_cmd_r;
  logic [31:0] s1_px_r;

  // stage 2: layout resolved, word masked to pixel size
  pcfc_layout_t s2_lay_r;
  logic         s2_cmd_r;
  logic [31:0]  s2_px_r;
  pcfc_layout_t lay_nxt;

  // stage 3: divide operands per channel
  pcfc_lane_t [NUM_CH-1:0] s3_lane_r;
  pcfc_lane_t [NUM_CH-1:0] lane_nxt;
  pcfc_place_t             s3_pl_r;
  pcfc_place_t             s4_pl_r;
  pcfc_place_t             s5_pl_r;

  // stage 5 quotients come out of the lanes
  logic [NUM_CH-1:0][7:0] q;

  // stage 6: output register
  logic [31:0] out_conv_r;
  logic        out_fb_r;
  logic [31:0] conv_nxt;

  // ---------------------------------------------------------------------
  // Configuration writes; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.off[CH_RED]   <= 5'd16;
      cfg_r.wid[CH_RED]   <= 5'd8;
      cfg_r.off[CH_GREEN] <= 5'd8;
      cfg_r.wid[CH_GREEN] <= 5'd8;
      cfg_r.off[CH_BLUE]  <= 5'd0;
      cfg_r.wid[CH_BLUE]  <= 5'd8;
      cfg_r.is32          <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RED_OFFSET:     cfg_r.off[CH_RED]   <= cfg_wdata;
        REG_RED_WIDTH:      cfg_r.wid[CH_RED]   <= cfg_wdata;
        REG_GREEN_OFFSET:   cfg_r.off[CH_GREEN] <= cfg_wdata;
        REG_GREEN_WIDTH:    cfg_r.wid[CH_GREEN] <= cfg_wdata;
        REG_BLUE_OFFSET:    cfg_r.off[CH_BLUE]  <= cfg_wdata;
        REG_BLUE_WIDTH:     cfg_r.wid[CH_BLUE]  <= cfg_wdata;
        REG_PIXEL_IS_32BIT: cfg_r.is32          <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline flow control: a stage loads when it is empty or its
  // successor loads, so bubbles collapse and a full pipe stalls in place.
  always_comb begin
    rdy[NSTG+1] = out_ch.ready;
    for (int k = NSTG; k >= 1; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign in_ch.ready = rdy[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[1]) vld_r[1] <= in_ch.valid;
      for (int k = 2; k <= NSTG; k++) begin
        if (rdy[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: capture the transfer.
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_cmd_r <= in_ch.command;
      s1_px_r  <= in_ch.pixel_value;
    end
  end

  // Stage 2: layout check against the (static) config registers.
  pcfc_layout u_layout (
    .cfg    (cfg_r),
    .layout (lay_nxt)
  );

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s2_lay_r <= lay_nxt;
      s2_cmd_r <= s1_cmd_r;
      s2_px_r  <= cfg_r.is32 ? s1_px_r : {8'h00, s1_px_r[23:0]};
    end
  end

  // Stage 3: pick out each channel and form the dividend.
  always_comb begin
    logic [31:0] shifted;
    for (int c = 0; c < NUM_CH; c++) begin
      shifted     = s2_px_r >> s2_lay_r.off[c];
      lane_nxt[c] = lane_prep(s2_cmd_r, s2_px_r[c*8 +: 8],
                              shifted[7:0] & field_ones(s2_lay_r.wid[c]),
                              s2_lay_r.wid[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s3_lane_r        <= lane_nxt;
      s3_pl_r.cmd      <= s2_cmd_r;
      s3_pl_r.off      <= s2_lay_r.off;
      s3_pl_r.fallback <= s2_lay_r.fallback;
      s3_pl_r.is32     <= s2_lay_r.is32;
    end
  end

  // Stages 4 and 5: divide lanes, control rides alongside.
  for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
    pcfc_scale u_scale (
      .clk     (clk),
      .en_mul  (rdy[4]),
      .en_fix  (rdy[5]),
      .lane_in (s3_lane_r[c]),
      .q       (q[c])
    );
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) s4_pl_r <= s3_pl_r;
    if (rdy[5]) s5_pl_r <= s4_pl_r;
  end

  // Stage 6: place fields (pack) or assemble 0x00RRGGBB (unpack).
  always_comb begin
    if (s5_pl_r.cmd == CMD_PACK) begin
      conv_nxt = '0;
      for (int c = 0; c < NUM_CH; c++) begin
        conv_nxt = conv_nxt | (32'(q[c]) << s5_pl_r.off[c]);
      end
      if (!s5_pl_r.is32) conv_nxt[31:24] = 8'h00;
    end else begin
      conv_nxt = {8'h00, q[CH_RED], q[CH_GREEN], q[CH_BLUE]};
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      out_conv_r <= conv_nxt;
      out_fb_r   <= s5_pl_r.fallback;
    end
  end

  assign out_ch.valid           = vld_r[NSTG];
  assign out_ch.converted       = out_conv_r;
  assign out_ch.layout_fallback = out_fb_r;

endmodule

// ===== src/pcfc_layout.sv =====
// Layout checker: validates the configured field layout and substitutes
// 8:8:8 at 16/8/0 when it is invalid. Depends on pcfc_pkg.
module pcfc_layout (
  input  pcfc_pkg::pcfc_cfg_t    cfg,
  output pcfc_pkg::pcfc_layout_t layout
);
  import pcfc_pkg::*;

  logic [5:0]                bpp;
  logic [NUM_CH-1:0][31:0]   mask;
  logic [NUM_CH-1:0]         fld_ok;
  logic                      ok;

  assign bpp = cfg.is32 ? 6'd32 : 6'd24;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      fld_ok[c] = (cfg.wid[c] != 5'd0) && (cfg.wid[c] <= 5'd8) &&
                  ((6'(cfg.off[c]) + 6'(cfg.wid[c])) <= bpp);
      mask[c]   = 32'(field_ones(cfg.wid[c][3:0])) << cfg.off[c];
    end
  end

  assign ok = (&fld_ok) &&
              ((mask[CH_RED] & mask[CH_GREEN]) == 32'd0) &&
              ((mask[CH_RED] & mask[CH_BLUE]) == 32'd0) &&
              ((mask[CH_GREEN] & mask[CH_BLUE]) == 32'd0);

  always_comb begin
    layout.fallback = !ok;
    layout.is32     = cfg.is32;
    for (int c = 0; c < NUM_CH; c++) begin
      layout.off[c] = ok ? cfg.off[c] : 5'(c * 8);
      layout.wid[c] = ok ? cfg.wid[c][3:0] : 4'd8;
    end
  end

endmodule

// ===== src/pcfc_scale.sv =====
// Divide lane: x / (2^dw - 1) by reciprocal multiply plus one correction
// step, two register stages. Depends on pcfc_pkg.
module pcfc_scale (
  input  logic                 clk,
  input  logic                 en_mul,
  input  logic                 en_fix,
  input  pcfc_pkg::pcfc_lane_t lane_in,
  output logic [7:0]           q
);
  import pcfc_pkg::*;

  logic [X_W-1:0]  x_r;
  logic [DW_W-1:0] dw_r;
  logic [QE_W-1:0] qe_r;
  logic [7:0]      q_r;

  logic [31:0]     prod;
  logic [7:0]      d;
  logic [23:0]     qd;
  logic [23:0]     rem;
  logic [QE_W-1:0] q_nxt;

  // estimate never exceeds the true quotient and is at most one below it
  assign prod = 32'(lane_in.x) * 32'(recip(lane_in.dw));

  assign d     = field_ones(dw_r);
  assign qd    = 24'(qe_r) * 24'(d);
  assign rem   = 24'(x_r) - qd;
  assign q_nxt = (rem >= 24'(d)) ? qe_r + 16'd1 : qe_r;

  always_ff @(posedge clk) begin
    if (en_mul) begin
      x_r  <= lane_in.x;
      dw_r <= lane_in.dw;
      qe_r <= prod[31:16];
    end
    if (en_fix) begin
      q_r <= q_nxt[7:0];
    end
  end

  assign q = q_r;

endmodule

// ===== dv/tb_pixel_channel_format_convert.sv =====
// Self-checking testbench for pixel_channel_format_convert: directed table plus random pixels
// over random and broken field layouts, scored against an in-bench conversion model.
// Depends on pcfc_pkg, pcfc_ifs and pixel_channel_format_convert from the RTL.
module tb_pixel_channel_format_convert;
  timeunit 1ns;
  timeprecision 1ps;

  import pcfc_pkg::*;

  // No register lives at this index; a write to it must be dropped.
  localparam logic [2:0] REG_NONE = 3'd7;

  localparam int ITEMS_PER_PHASE = 575;
  localparam int DRAIN_CYCLES    = 16;   // pipeline is six deep, leave slack
  // Idle percentages per random phase: receiver slow, then sender slow, then none.
  localparam int SEND_IDLE [3] = '{30, 60, 0};
  localparam int RECV_IDLE [3] = '{60, 30, 0};

  typedef enum logic {ROW_WRITE, ROW_PIXEL} step_kind_t;

  // One line of the directed table. Pixel rows use cmd/px and, when typed is set,
  // the hand-written conv/fb; write rows use idx/val.
  typedef struct packed {
    step_kind_t  kind;
    logic        cmd;
    logic [31:0] px;
    logic        typed;
    logic [31:0] conv;
    logic        fb;
    logic [2:0]  idx;
    logic [4:0]  val;
  } step_t;

  typedef struct packed {
    logic [31:0] converted;
    logic        layout_fallback;
  } pixel_result_t;

  localparam int NUM_STEPS = 51;
  localparam step_t STEPS [NUM_STEPS] = '{
    // reset layout, 8:8:8 at 16/8/0, 32-bit
    '{ROW_PIXEL, CMD_PACK,   32'h00FF_FFFF, 1'b1, 32'h00FF_FFFF, 1'b0, '0, '0},
    '{ROW_PIXEL, CMD_PACK,   32'hFF12_3456, 1'b1, 32'h0012_3456, 1'b0, '0, '0},
    '{ROW_PIXEL, CMD_UNPACK, 32'hFFFF_FFFF, 1'b1, 32'h00FF_FFFF, 1'b0, '0, '0},
    '{ROW_PIXEL, CMD_UNPACK, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0, '0, '0},
    // 5:6:5 at 11/5/0
    '{ROW_WRITE, CMD_PACK, '0, 1'b0, '0, 1'b0, REG_RED_OFFSET,   5'd11},
    '{ROW_WRITE, CMD_PACK, '0, 1'b0, '0, 1'b0, REG_RED_WIDTH,    5'd5},
    '{ROW_WRITE, CMD_PACK, '0, 1'b0, '0, 1'b0, REG_GREEN_OFFSET, 5'd5},
    '{ROW_WRITE, CMD_PACK, '0, 1'b0, '0, 1'b0, REG_GREEN_WIDTH,  5'd6},
    '{ROW_WRITE, CMD_PACK, '0, 1'b0, '0, 1'b0, REG_BLUE_OFFSET,  5'd0},
    '{ROW_WRITE, CMD_PACK, '0, 1'b0, '0, 1'b0, REG_BLUE_WIDTH,   5'd5},
    '{ROW_PIXEL, CMD_PACK,   32'h00FF_FFFF, 1'b1, 32'h0000_FFFF, 1'b0, '0, '0},
    '{ROW_PIXEL, CMD_PACK,   32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0, '0, '0},
    '{ROW_PIXEL, CMD_UNPACK, 32'hFFFF_FFFF, 1'b1, 32'h00FF_FFFF, 1'b0, '0, '0},
    '{ROW_PIXEL, CMD_PACK,   32'h0080_4020, 1'b0, '0,            1'b0, '0, '0},
    '{ROW_PIXEL, CMD_UNPACK, 32'h0000_A5C3, 1'b0, '0,            1'b0, '0, '0},
    // zero width -> default layout
    '{ROW_WRITE, CMD_PACK, '0, 1'b0, '0, 1'b0, REG_BLUE_WIDTH,   5'd0},
    '{ROW_PIXEL, CMD_PACK,   32'h0012_3456, 1'b1, 32'h0012_3456, 1'b1, '0, '0},
    '{ROW_PIXEL, CMD_UNPACK, 32'hABCD_EF12, 1'b1, 32'h00CD_EF12, 1'b1, '0, '0},
    // oversized widths, largest and just past 8
    '{ROW_WRITE, CMD_PACK, '0, 1'b0, '0, 1'b0, REG_BLUE_WIDTH,   5'd31},
    '{ROW_PIXEL, CMD_PACK,   32'h00AB_CDEF, 1'b1, 32'h00AB_CDEF, 1'b1, '0, '0},
    '{ROW_WRITE, CMD_PACK, '0, 1'b0, '0, 1'b0, REG_BLUE_WIDTH,   5'd9},
    '{ROW_PIXEL, CMD_UNPACK, 32'h0012_3456, 1'b1, 32'h0012_3456, 1'b1, '0, '0},
    // green shifted onto blue's top bit -> overlap
    '{ROW_WRITE, CMD_PACK, '0, 1'b0, '0, 1'b0, REG_BLUE_WIDTH,   5'd5},
    '{ROW_WRITE, CMD_PACK, '0, 1'b0, '0, 1'b0, REG_GREEN_OFFSET, 5'd4},
    '{ROW_PIXEL, CMD_PACK,   32'h00FF_0000, 1'b1, 32'h00FF_0000, 1'b1, '0, '0},
    // 1-bit red at the very top of a 32-bit word
    '{ROW_WRITE, CMD_PACK, '0, 1'b0, '0, 1'b0, REG_GREEN_OFFSET, 5'd5},
    '{ROW_WRITE, CMD_PACK, '0, 1'b0, '0, 1'b0, REG_RED_OFFSET,   5'd31},
    '{ROW_WRITE, CMD_PACK, '0, 1'b0, '0, 1'b0, REG_RED_WIDTH,    5'd1},
    '{ROW_PIXEL, CMD_PACK,   32'h00FF_0000, 1'b1, 32'h8000_0000, 1'b0, '0, '0},
    '{ROW_PIXEL, CMD_UNPACK, 32'h8000_0000, 1'b1, 32'h00FF_0000, 1'b0, '0, '0},
    '{ROW_PIXEL, CMD_PACK,   32'h007F_0000, 1'b0, '0,            1'b0, '0, '0},
    // 24-bit mode (only bit 0 of the write counts): red at 31 now lies outside
    '{ROW_WRITE, CMD_PACK, '0, 1'b0, '0, 1'b0, REG_PIXEL_IS_32BIT, 5'd30},
    '{ROW_PIXEL, CMD_PACK,   32'h00FF_FFFF, 1'b1, 32'h00FF_FFFF, 1'b1, '0, '0},
    '{ROW_PIXEL, CMD_UNPACK, 32'hFF00_0000, 1'b1, 32'h0000_0000, 1'b1, '0, '0},
    // default layout written explicitly, still valid at 24 bits
    '{ROW_WRITE, CMD_PACK, '0, 1'b0, '0, 1'b0, REG_RED_OFFSET,   5'd16},
    '{ROW_WRITE, CMD_PACK, '0, 1'b0, '0, 1'b0, REG_RED_WIDTH,    5'd8},
    '{ROW_WRITE, CMD_PACK, '0, 1'b0, '0, 1'b0, REG_GREEN_OFFSET, 5'd8},
    '{ROW_WRITE, CMD_PACK, '0, 1'b0, '0, 1'b0, REG_GREEN_WIDTH,  5'd8},
    '{ROW_WRITE, CMD_PACK, '0, 1'b0, '0, 1'b0, REG_BLUE_WIDTH,   5'd8},
    '{ROW_PIXEL, CMD_UNPACK, 32'hFF12_3456, 1'b1, 32'h0012_3456, 1'b0, '0, '0},
    '{ROW_PIXEL, CMD_PACK,   32'hFFFF_FFFF, 1'b1, 32'h00FF_FFFF, 1'b0, '0, '0},
    // red reaching bit 24 is one past a 24-bit pixel, fine at 32
    '{ROW_WRITE, CMD_PACK, '0, 1'b0, '0, 1'b0, REG_RED_OFFSET,   5'd17},
    '{ROW_PIXEL, CMD_PACK,   32'h0001_0203, 1'b1, 32'h0001_0203, 1'b1, '0, '0},
    '{ROW_WRITE, CMD_PACK, '0, 1'b0, '0, 1'b0, REG_PIXEL_IS_32BIT, 5'd1},
    '{ROW_PIXEL, CMD_PACK,   32'h00FF_FFFF, 1'b0, '0,            1'b0, '0, '0},
    // write to an unused index must change nothing
    '{ROW_WRITE, CMD_PACK, '0, 1'b0, '0, 1'b0, REG_NONE,         5'd3},
    '{ROW_PIXEL, CMD_UNPACK, 32'h01FE_FFFF, 1'b0, '0,            1'b0, '0, '0},
    // all fields one bit wide
    '{ROW_WRITE, CMD_PACK, '0, 1'b0, '0, 1'b0, REG_RED_WIDTH,    5'd1},
    '{ROW_WRITE, CMD_PACK, '0, 1'b0, '0, 1'b0, REG_GREEN_WIDTH,  5'd1},
    '{ROW_WRITE, CMD_PACK, '0, 1'b0, '0, 1'b0, REG_BLUE_WIDTH,   5'd1},
    '{ROW_PIXEL, CMD_UNPACK, 32'h0002_0101, 1'b0, '0,            1'b0, '0, '0}
  };

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [2:0] cfg_index;
  logic [4:0] cfg_wdata;

  pcfc_in_if  in_ch ();
  pcfc_out_if out_ch ();

  pixel_channel_format_convert DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow copy of the layout registers, indexed by channel (blue 0, green 1, red 2).
  logic [4:0] lay_off [NUM_CH];
  logic [4:0] lay_wid [NUM_CH];
  logic       lay_is32;

  // Conversions owed by the block, oldest first.
  pixel_result_t conversions_due [$];

  int send_idle_pct;
  int recv_idle_pct;
  int mismatch_count;
  int checked_count;
  int pack_count;
  int unpack_count;
  int fallback_count;
  int write_count;
  int layout_count;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Conversion model
  // ---------------------------------------------------------------------------

  function automatic logic [31:0] field_mask(input int unsigned w);
    return (32'd1 << w) - 32'd1;
  endfunction

  // 8-bit channel down to w bits, round to nearest
  function automatic int unsigned shrink_channel(input int unsigned v, input int unsigned w);
    if (w == 8) return v;
    return (v * field_mask(w) + 127) / 255;
  endfunction

  // w-bit field back up to 8 bits, round to nearest
  function automatic int unsigned widen_field(input int unsigned raw, input int unsigned w);
    int unsigned top;
    top = field_mask(w);
    if (w == 8) return raw & 32'hFF;
    return (raw * 255 + top / 2) / top;
  endfunction

  // Widths 1..8, every field inside the pixel, no shared bits.
  function automatic bit layout_valid(input int unsigned bpp);
    logic [31:0] taken;
    logic [31:0] m;
    taken = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      if (lay_wid[c] == 5'd0 || lay_wid[c] > 5'd8) return 1'b0;
      if (int'(lay_off[c]) + int'(lay_wid[c]) > int'(bpp)) return 1'b0;
      m = field_mask(lay_wid[c]) << lay_off[c];
      if ((taken & m) != 32'd0) return 1'b0;
      taken |= m;
    end
    return 1'b1;
  endfunction

  function automatic pixel_result_t convert_pixel(input logic cmd, input logic [31:0] px);
    int unsigned off [NUM_CH];
    int unsigned wid [NUM_CH];
    logic [31:0] word_mask;
    logic [31:0] word;
    logic [31:0] phys;
    pixel_result_t r;
    word_mask = lay_is32 ? 32'hFFFF_FFFF : 32'h00FF_FFFF;
    r.layout_fallback = !layout_valid(lay_is32 ? 32 : 24);
    // Fallback is 8:8:8 with each channel at its own byte position.
    for (int c = 0; c < NUM_CH; c++) begin
      off[c] = r.layout_fallback ? 8 * c : lay_off[c];
      wid[c] = r.layout_fallback ? 8 : lay_wid[c];
    end
    word = '0;
    phys = px & word_mask;
    for (int c = 0; c < NUM_CH; c++) begin
      if (cmd == CMD_PACK)
        word |= 32'(shrink_channel(px[8*c +: 8], wid[c])) << off[c];
      else
        word |= 32'(widen_field((phys >> off[c]) & field_mask(wid[c]), wid[c])) << (8 * c);
    end
    if (cmd == CMD_PACK) word &= word_mask;
    r.converted = word;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Register write, only with nothing in flight: drops valid and waits for every
  // owed conversion first. This is also where the sender holds off until the
  // pipeline is empty. cfg_we is left high; the next pixel lowers it.
  task automatic write_reg(input logic [2:0] idx, input logic [4:0] val);
    in_ch.valid <= 1'b0;
    while (conversions_due.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_RED_OFFSET:     lay_off[CH_RED]   = val;
      REG_RED_WIDTH:      lay_wid[CH_RED]   = val;
      REG_GREEN_OFFSET:   lay_off[CH_GREEN] = val;
      REG_GREEN_WIDTH:    lay_wid[CH_GREEN] = val;
      REG_BLUE_OFFSET:    lay_off[CH_BLUE]  = val;
      REG_BLUE_WIDTH:     lay_wid[CH_BLUE]  = val;
      REG_PIXEL_IS_32BIT: lay_is32          = val[0];
      default: ;
    endcase
    write_count++;
    @(posedge clk);
  endtask

  // One pixel transfer. valid stays high on return so back-to-back pixels never
  // see valid dropped and raised in one step; the idle loop or a write lowers it.
  task automatic send_pixel(input logic cmd, input logic [31:0] px, input logic typed,
                            input logic [31:0] conv, input logic fb);
    pixel_result_t due;
    cfg_we <= 1'b0;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.command     <= cmd;
    in_ch.pixel_value <= px;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    // transfer taken at this edge
    if (typed) begin
      due.converted       = conv;
      due.layout_fallback = fb;
    end else begin
      due = convert_pixel(cmd, px);
    end
    conversions_due.push_back(due);
    if (cmd == CMD_PACK) pack_count++;
    else unpack_count++;
    if (due.layout_fallback) fallback_count++;
  endtask

  // New random layout. Most are valid with fields packed in random order and
  // random gaps; the rest are broken on purpose (random junk, bad width, field
  // past the pixel, overlap) so the fallback path keeps getting exercised.
  task automatic retarget_layout();
    int unsigned w [NUM_CH];
    int unsigned o [NUM_CH];
    int unsigned order [NUM_CH];
    int unsigned bpp, slack, pos, gap, j, tmp, c, d;
    logic is32;
    is32 = 1'($urandom_range(0, 1));
    bpp  = is32 ? 32 : 24;
    for (int i = 0; i < NUM_CH; i++) begin
      case ($urandom_range(0, 3))
        0:       w[i] = 1;
        1:       w[i] = 8;
        default: w[i] = $urandom_range(1, 8);
      endcase
      order[i] = i;
    end
    for (int i = NUM_CH - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    // three fields of at most 8 bits always fit in 24
    slack = bpp - (w[0] + w[1] + w[2]);
    pos   = 0;
    for (int i = 0; i < NUM_CH; i++) begin
      gap          = $urandom_range(0, slack);
      slack       -= gap;
      o[order[i]]  = pos + gap;
      pos         += gap + w[order[i]];
    end
    c = $urandom_range(0, NUM_CH - 1);
    d = (c + 1) % NUM_CH;
    case ($urandom_range(0, 8))
      0: for (int i = 0; i < NUM_CH; i++) begin
        o[i] = $urandom_range(0, 31);
        w[i] = $urandom_range(0, 31);
      end
      1: w[c] = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(9, 31);
      2: begin
        if (is32) begin
          w[c] = $urandom_range(2, 8);
          o[c] = 31;
        end else begin
          o[c] = $urandom_range(25 - w[c], 31);
        end
      end
      3: o[c] = o[d];
      default: ;
    endcase
    write_reg(REG_RED_OFFSET,     5'(o[CH_RED]));
    write_reg(REG_RED_WIDTH,      5'(w[CH_RED]));
    write_reg(REG_GREEN_OFFSET,   5'(o[CH_GREEN]));
    write_reg(REG_GREEN_WIDTH,    5'(w[CH_GREEN]));
    write_reg(REG_BLUE_OFFSET,    5'(o[CH_BLUE]));
    write_reg(REG_BLUE_WIDTH,     5'(w[CH_BLUE]));
    write_reg(REG_PIXEL_IS_32BIT, {4'($urandom_range(0, 15)), is32});
    layout_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: score every output transfer, then pick next ready at random.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    pixel_result_t want;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (conversions_due.size() == 0) begin
          $error("transfer with nothing owed: converted %h layout_fallback %b",
                 out_ch.converted, out_ch.layout_fallback);
          mismatch_count++;
        end else begin
          want = conversions_due.pop_front();
          if (out_ch.converted !== want.converted) begin
            $error("converted: expected %h, got %h", want.converted, out_ch.converted);
            mismatch_count++;
          end
          if (out_ch.layout_fallback !== want.layout_fallback) begin
            $error("layout_fallback: expected %b, got %b",
                   want.layout_fallback, out_ch.layout_fallback);
            mismatch_count++;
          end
          checked_count++;
        end
      end
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int sent;
    int burst;
    logic cmd;
    logic [31:0] px;

    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= REG_RED_OFFSET;
    cfg_wdata         <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.command     <= CMD_PACK;
    in_ch.pixel_value <= '0;

    // shadow registers at their reset values
    lay_off[CH_RED]   = 5'd16;
    lay_wid[CH_RED]   = 5'd8;
    lay_off[CH_GREEN] = 5'd8;
    lay_wid[CH_GREEN] = 5'd8;
    lay_off[CH_BLUE]  = 5'd0;
    lay_wid[CH_BLUE]  = 5'd8;
    lay_is32          = 1'b1;

    mismatch_count = 0;
    checked_count  = 0;
    pack_count     = 0;
    unpack_count   = 0;
    fallback_count = 0;
    write_count    = 0;
    layout_count   = 0;
    send_idle_pct  = SEND_IDLE[0];
    recv_idle_pct  = RECV_IDLE[0];

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, run with the first idle mix
    for (int k = 0; k < NUM_STEPS; k++) begin
      if (STEPS[k].kind == ROW_WRITE)
        write_reg(STEPS[k].idx, STEPS[k].val);
      else
        send_pixel(STEPS[k].cmd, STEPS[k].px, STEPS[k].typed, STEPS[k].conv, STEPS[k].fb);
    end

    // random bursts, each on a fresh layout
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = SEND_IDLE[phase];
      recv_idle_pct = RECV_IDLE[phase];
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        retarget_layout();
        burst = $urandom_range(10, 60);
        for (int n = 0; n < burst; n++) begin
          cmd = 1'($urandom_range(0, 1));
          case ($urandom_range(0, 15))
            0:       px = '0;
            1:       px = '1;
            default: px = $urandom;
          endcase
          send_pixel(cmd, px, 1'b0, '0, 1'b0);
        end
        sent += burst;
      end
    end

    in_ch.valid <= 1'b0;
    cfg_we      <= 1'b0;
    while (conversions_due.size() != 0) @(posedge clk);
    // catch anything extra the pipeline still pushes out
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Scored %0d pixels (%0d pack, %0d unpack), %0d of them on the fallback layout.",
             checked_count, pack_count, unpack_count, fallback_count);
    $display("%0d register writes, %0d random layouts, three idle mixes on both sides.",
             write_count, layout_count);
    if (mismatch_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // Hard stop, far beyond the slowest legal run.
  initial begin : watchdog
    #1_000_000;
    $display("timed out with %0d conversions still owed", conversions_due.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== pixel_channel_format_convert.f =====
src/pcfc_pkg.sv
src/pcfc_ifs.sv
src/pcfc_layout.sv
src/pcfc_scale.sv
src/pixel_channel_format_convert.sv
dv/tb_pixel_channel_format_convert.sv
